// ----- design/kpat_pkg.sv -----
// Shared types and constants for the keypad autorepeat and touch latch unit.
`default_nettype none
package kpat_pkg;

	localparam int KEY_W      = 16;
	localparam int COORD_W    = 8;
	localparam int TIMER_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int KEY_BITS_DEF = 16;

	// key bit positions
	localparam int KEY_A_BIT     = 0;
	localparam int KEY_START_BIT = 3;
	localparam int KEY_R_BIT     = 8;
	localparam int KEY_L_BIT     = 9;
	localparam int KEY_X_BIT     = 10;
	localparam int KEY_Y_BIT     = 11;

	localparam logic [1:0]         BUTTON_MODE_RST  = 2'd0;
	localparam logic [TIMER_W-1:0] REPEAT_RATE_RST  = 8'd4;
	localparam logic [TIMER_W-1:0] REPEAT_DELAY_RST = 8'd8;

	typedef enum logic [1:0] {
		BTN_NORMAL  = 2'd0,
		BTN_START_X = 2'd1,
		BTN_SWAP_XY = 2'd2,
		BTN_L_IS_A  = 2'd3
	} btn_mode_t;

	typedef enum logic [1:0] {
		VAL_OK       = 2'd0,
		VAL_X_BAD    = 2'd1,
		VAL_Y_BAD    = 2'd2,
		VAL_BOTH_BAD = 2'd3
	} validity_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUTTON_MODE  = 2'd0,
		REG_REPEAT_RATE  = 2'd1,
		REG_REPEAT_DELAY = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               lid_closed;
		logic [KEY_W-1:0]   raw_keys;
		logic               sample_touch;
		logic [COORD_W-1:0] sample_x;
		logic [COORD_W-1:0] sample_y;
		logic [1:0]         sample_validity;
	} in_word_t;

	typedef struct packed {
		logic [KEY_W-1:0]   held_keys;
		logic [KEY_W-1:0]   pressed_keys;
		logic [KEY_W-1:0]   repeat_keys;
		logic [COORD_W-1:0] touch_x_out;
		logic [COORD_W-1:0] touch_y_out;
		logic               touch_pressed;
		logic               touch_held;
	} out_word_t;

endpackage
`default_nettype wire

// ----- design/kpat_ifs.sv -----
// Valid/ready channel interfaces for the input and result words.
`default_nettype none
interface kpat_in_if;
	logic                valid;
	logic                ready;
	kpat_pkg::in_word_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface kpat_out_if;
	logic                valid;
	logic                ready;
	kpat_pkg::out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/keypad_autorepeat_touch_latch_unit.sv -----
// Keypad edge detect with autorepeat, button remap and touch latch, top level.
//
// Usage:
//   sample : one word per frame tick (lid state, raw keys, one touch sample).
//   result : one word per sample word: held, pressed and repeat keys after
//            button remap, latched touch position, touch press and hold.
//   cfg_we/cfg_index/cfg_data : register writes (button mode, repeat rate,
//            repeat delay); write only while no word is in flight.
// Path: an accepted word goes to the input register, then to the result register
//   fed by the key/touch logic and state update, once that register can advance.
// Throughput: one word per cycle while result is taken; the only loop is the
//   update of the key history, repeat timer and touch latch.
// Stall: when result is not taken the result register holds; the input
//   register still takes one more word, then sample.ready drops.
// Reset: pipeline empty, key history, timer and touch latch cleared,
//   button mode 0, repeat rate 4, repeat delay 8.
`default_nettype none
module keypad_autorepeat_touch_latch_unit #(
	parameter int KEY_BITS = kpat_pkg::KEY_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	kpat_in_if.sink                                sample,
	kpat_out_if.source                             result,
	input  wire logic                              cfg_we,
	input  wire logic [kpat_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kpat_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// keys above KEY_BITS are dropped; the raw field is 16 bits wide
	localparam int KW = (KEY_BITS < kpat_pkg::KEY_W) ? KEY_BITS : kpat_pkg::KEY_W;

	kpat_pkg::btn_mode_t                 button_mode_q;
	logic [kpat_pkg::TIMER_W-1:0]        repeat_rate_q;
	logic [kpat_pkg::TIMER_W-1:0]        repeat_delay_q;

	logic [KW-1:0]                       prev_keys_q;
	logic [kpat_pkg::TIMER_W-1:0]        timer_q;
	logic                                prev_touch_q;
	logic [kpat_pkg::COORD_W-1:0]        last_x_q;
	logic [kpat_pkg::COORD_W-1:0]        last_y_q;

	logic                                valid_s1;
	kpat_pkg::in_word_t                  word_s1;
	logic                                valid_s2;
	kpat_pkg::out_word_t                 word_s2;

	logic                                advance;

	logic [KW-1:0]                       keys;
	logic [KW-1:0]                       pressed;
	logic [KW-1:0]                       rep;
	logic [kpat_pkg::TIMER_W-1:0]        timer_dec;
	logic [kpat_pkg::TIMER_W-1:0]        timer_nxt;
	logic                                touch;
	logic                                tpress;
	logic [kpat_pkg::COORD_W-1:0]        x_nxt;
	logic [kpat_pkg::COORD_W-1:0]        y_nxt;
	kpat_pkg::out_word_t                 word_nxt;

	function automatic logic [KW-1:0] remap(input kpat_pkg::btn_mode_t mode,
			input logic [KW-1:0] k);
		logic [KW-1:0] r;
		r = k;
		case (mode)
			kpat_pkg::BTN_START_X: begin
				if (k[kpat_pkg::KEY_START_BIT])
					r[kpat_pkg::KEY_X_BIT] = 1'b1;
			end
			kpat_pkg::BTN_SWAP_XY: begin
				r[kpat_pkg::KEY_X_BIT] = k[kpat_pkg::KEY_Y_BIT];
				r[kpat_pkg::KEY_Y_BIT] = k[kpat_pkg::KEY_X_BIT];
			end
			kpat_pkg::BTN_L_IS_A: begin
				if (k[kpat_pkg::KEY_L_BIT])
					r[kpat_pkg::KEY_A_BIT] = 1'b1;
				r[kpat_pkg::KEY_L_BIT] = 1'b0;
				r[kpat_pkg::KEY_R_BIT] = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign result.valid = valid_s2;
	assign result.payload = word_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_mode_q  <= kpat_pkg::btn_mode_t'(kpat_pkg::BUTTON_MODE_RST);
			repeat_rate_q  <= kpat_pkg::REPEAT_RATE_RST;
			repeat_delay_q <= kpat_pkg::REPEAT_DELAY_RST;
		end else if (cfg_we) begin
			case (kpat_pkg::cfg_reg_t'(cfg_index))
				kpat_pkg::REG_BUTTON_MODE:  button_mode_q  <= kpat_pkg::btn_mode_t'(cfg_data[1:0]);
				kpat_pkg::REG_REPEAT_RATE:  repeat_rate_q  <= cfg_data;
				kpat_pkg::REG_REPEAT_DELAY: repeat_delay_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// key and touch logic on the registered input word
	always_comb begin
		keys      = word_s1.raw_keys[KW-1:0];
		pressed   = keys & ~prev_keys_q;
		rep       = pressed;
		timer_dec = timer_q - 1'b1;
		timer_nxt = repeat_delay_q;
		if (keys != '0 && keys == prev_keys_q) begin
			timer_nxt = timer_dec;
			if (timer_dec == '0) begin
				rep       = keys;
				timer_nxt = repeat_rate_q;
			end
		end

		touch = word_s1.sample_touch;
		x_nxt = last_x_q;
		y_nxt = last_y_q;
		if (kpat_pkg::validity_t'(word_s1.sample_validity) == kpat_pkg::VAL_OK) begin
			x_nxt = word_s1.sample_x;
			y_nxt = word_s1.sample_y;
		end else if (prev_touch_q) begin
			// partial update keeps the bad axis
			if (kpat_pkg::validity_t'(word_s1.sample_validity) == kpat_pkg::VAL_X_BAD)
				y_nxt = word_s1.sample_y;
			else if (kpat_pkg::validity_t'(word_s1.sample_validity) == kpat_pkg::VAL_Y_BAD)
				x_nxt = word_s1.sample_x;
		end else begin
			touch = 1'b0;
		end
		tpress = touch && !prev_touch_q;

		word_nxt               = '0;
		if (!word_s1.lid_closed) begin
			word_nxt.held_keys     = kpat_pkg::KEY_W'(remap(button_mode_q, keys));
			word_nxt.pressed_keys  = kpat_pkg::KEY_W'(remap(button_mode_q, pressed));
			word_nxt.repeat_keys   = kpat_pkg::KEY_W'(remap(button_mode_q, rep));
			word_nxt.touch_x_out   = x_nxt;
			word_nxt.touch_y_out   = y_nxt;
			word_nxt.touch_pressed = tpress;
			word_nxt.touch_held    = touch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q  <= '0;
			timer_q      <= '0;
			prev_touch_q <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
		end else if (advance) begin
			if (word_s1.lid_closed) begin
				prev_touch_q <= 1'b0;
			end else begin
				prev_keys_q  <= keys;
				timer_q      <= timer_nxt;
				prev_touch_q <= touch;
				last_x_q     <= x_nxt;
				last_y_q     <= y_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready)
			word_s1 <= sample.payload;
		if (advance)
			word_s2 <= word_nxt;
	end

endmodule
`default_nettype wire

// ----- design/kpat_checker.sv -----
// Port-level checks for the keypad autorepeat and touch latch unit, with bind.
`default_nettype none
module kpat_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire kpat_pkg::out_word_t  out_word
);

	// a held result word must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// input side only backs up once the result register is full
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("sample stalled with result register empty");

	// pressed keys are repeat keys, repeat keys are held keys
	a_key_sets: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_word.pressed_keys & ~out_word.repeat_keys) == '0) &&
			((out_word.repeat_keys & ~out_word.held_keys) == '0))
		else $error("key sets not nested");

	a_touch_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.touch_pressed |-> out_word.touch_held)
		else $error("touch press without hold");

endmodule

bind keypad_autorepeat_touch_latch_unit kpat_checker u_kpat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_word  (result.payload)
);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the keypad autorepeat and touch latch unit.
`default_nettype none
module testbench;
	import kpat_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 40;

	localparam logic [KEY_W-1:0] M_A     = KEY_W'(1) << KEY_A_BIT;
	localparam logic [KEY_W-1:0] M_START = KEY_W'(1) << KEY_START_BIT;
	localparam logic [KEY_W-1:0] M_R     = KEY_W'(1) << KEY_R_BIT;
	localparam logic [KEY_W-1:0] M_L     = KEY_W'(1) << KEY_L_BIT;
	localparam logic [KEY_W-1:0] M_X     = KEY_W'(1) << KEY_X_BIT;
	localparam logic [KEY_W-1:0] M_Y     = KEY_W'(1) << KEY_Y_BIT;
	localparam logic [KEY_W-1:0] M_REMAPPED = M_A | M_START | M_R | M_L | M_X | M_Y;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kpat_in_if  smp();
	kpat_out_if res();

	keypad_autorepeat_touch_latch_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state and register copy
	btn_mode_t          cur_mode  = BTN_NORMAL;
	logic [TIMER_W-1:0] cur_rate  = REPEAT_RATE_RST;
	logic [TIMER_W-1:0] cur_delay = REPEAT_DELAY_RST;
	logic [KEY_W-1:0]   key_hist  = '0;
	logic [TIMER_W-1:0] rpt_timer = '0;
	logic               touch_prev = 1'b0;
	logic [COORD_W-1:0] lat_x = '0;
	logic [COORD_W-1:0] lat_y = '0;

	out_word_t pending_frames[$];

	int errors       = 0;
	int n_words      = 0;
	int n_checked    = 0;
	int n_bursts     = 0;
	int n_lid        = 0;
	int n_cfg_writes = 0;
	int src_pct      = 0;
	int snk_pct      = 0;
	int snk_wait     = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 12);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [KEY_W-1:0] apply_button_mode(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] m;
		m = k;
		case (cur_mode)
			BTN_START_X: begin
				if (k[KEY_START_BIT])
					m[KEY_X_BIT] = 1'b1;
			end
			BTN_SWAP_XY: begin
				m[KEY_X_BIT] = k[KEY_Y_BIT];
				m[KEY_Y_BIT] = k[KEY_X_BIT];
			end
			BTN_L_IS_A: begin
				if (k[KEY_L_BIT])
					m[KEY_A_BIT] = 1'b1;
				m[KEY_L_BIT] = 1'b0;
				m[KEY_R_BIT] = 1'b0;
			end
			default: begin
			end
		endcase
		return m;
	endfunction

	// advances the key history, repeat timer and touch latch by one frame tick
	function automatic out_word_t next_frame_result(input in_word_t w);
		out_word_t        r;
		logic [KEY_W-1:0] keys;
		logic [KEY_W-1:0] fresh;
		logic [KEY_W-1:0] burst;
		logic             t;
		r = '0;
		if (w.lid_closed) begin
			touch_prev = 1'b0;
			n_lid++;
			return r;
		end
		keys  = w.raw_keys;
		fresh = keys & ~key_hist;
		burst = fresh;
		if (keys != '0 && keys == key_hist) begin
			rpt_timer = rpt_timer - 1'b1;  // wraps from zero, no burst then
			if (rpt_timer == '0) begin
				burst     = keys;
				rpt_timer = cur_rate;
				n_bursts++;
			end
		end else begin
			rpt_timer = cur_delay;
		end
		key_hist = keys;

		t = w.sample_touch;
		if (w.sample_validity == VAL_OK) begin
			lat_x = w.sample_x;
			lat_y = w.sample_y;
		end else if (touch_prev) begin
			if (w.sample_validity == VAL_X_BAD)
				lat_y = w.sample_y;
			else if (w.sample_validity == VAL_Y_BAD)
				lat_x = w.sample_x;
		end else begin
			t = 1'b0;  // bad sample with no prior contact reads as released
		end
		r.touch_pressed = t & ~touch_prev;
		touch_prev      = t;

		r.held_keys    = apply_button_mode(keys);
		r.pressed_keys = apply_button_mode(fresh);
		r.repeat_keys  = apply_button_mode(burst);
		r.touch_x_out  = lat_x;
		r.touch_y_out  = lat_y;
		r.touch_held   = t;
		return r;
	endfunction

	function automatic in_word_t make_frame(input logic lid, input logic [KEY_W-1:0] keys,
			input logic touch, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input validity_t v);
		in_word_t w;
		w.lid_closed      = lid;
		w.raw_keys        = keys;
		w.sample_touch    = touch;
		w.sample_x        = x;
		w.sample_y        = y;
		w.sample_validity = v;
		return w;
	endfunction

	function automatic void check_field(input string fname, input logic [KEY_W-1:0] exp_v,
			input logic [KEY_W-1:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, got_v);
		end
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		gap = pick_gap(src_pct);
		@(negedge clk);
		if (gap > 0) begin
			smp.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.payload = w;
		smp.valid   = 1'b1;
		do
			@(posedge clk);
		while (!smp.ready);
		pending_frames.push_back(next_frame_result(w));
		n_words++;
	endtask

	// hold the sender until every outstanding result word has been taken
	task automatic wait_drained();
		@(negedge clk);
		smp.valid = 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
		wait_drained();
		repeat (3) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		case (idx)
			REG_BUTTON_MODE:  cur_mode  = btn_mode_t'(v[1:0]);
			REG_REPEAT_RATE:  cur_rate  = v;
			REG_REPEAT_DELAY: cur_delay = v;
			default: begin
			end
		endcase
		n_cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_key_repeat();
		write_reg(REG_REPEAT_DELAY, 8'd2);
		write_reg(REG_REPEAT_RATE, 8'd1);
		repeat (3) send_word(make_frame(1'b0, 16'h0F0F, 1'b0, 8'd0, 8'd0, VAL_OK));
		send_word(make_frame(1'b0, 16'hFFFF, 1'b0, 8'd0, 8'd0, VAL_OK));
		send_word(make_frame(1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, VAL_OK));
		// rate zero: burst, then the countdown wraps through 255
		write_reg(REG_REPEAT_RATE, 8'd0);
		repeat (4) send_word(make_frame(1'b0, 16'h8001, 1'b0, 8'd0, 8'd0, VAL_OK));
		// closed lid keeps key history and timer
		send_word(make_frame(1'b1, 16'hFFFF, 1'b1, 8'd255, 8'd191, VAL_OK));
		send_word(make_frame(1'b0, 16'h8001, 1'b0, 8'd0, 8'd0, VAL_OK));
	endtask

	task automatic test_touch_latch();
		send_word(make_frame(1'b0, '0, 1'b1, 8'd255, 8'd191, VAL_OK));
		send_word(make_frame(1'b0, '0, 1'b1, 8'd10, 8'd20, VAL_X_BAD));
		send_word(make_frame(1'b0, '0, 1'b1, 8'd30, 8'd40, VAL_Y_BAD));
		send_word(make_frame(1'b0, '0, 1'b1, 8'd50, 8'd60, VAL_BOTH_BAD));
		send_word(make_frame(1'b0, '0, 1'b0, 8'd0, 8'd0, VAL_OK));
		send_word(make_frame(1'b0, '0, 1'b1, 8'd70, 8'd80, VAL_X_BAD));
		send_word(make_frame(1'b1, '0, 1'b1, 8'd90, 8'd100, VAL_OK));
		send_word(make_frame(1'b0, '0, 1'b1, 8'd128, 8'd128, VAL_OK));
	endtask

	task automatic test_button_modes();
		btn_mode_t m;
		m = m.first();
		do begin
			write_reg(REG_BUTTON_MODE, 8'(m));
			send_word(make_frame(1'b0, '0, 1'b0, 8'd0, 8'd0, VAL_OK));
			send_word(make_frame(1'b0, M_REMAPPED, 1'b0, 8'd0, 8'd0, VAL_OK));
			m = m.next();
		end while (m != m.first());
	endtask

	task automatic test_random_phases();
		logic [TIMER_W-1:0] rate;
		logic [TIMER_W-1:0] dly;
		logic [KEY_W-1:0]   held_set;
		logic               contact;
		logic               lid;
		validity_t          v;
		int                 hold_left;
		int                 stroke_left;
		int                 lid_left;
		contact     = 1'b0;
		hold_left   = 0;
		stroke_left = 0;
		lid_left    = 0;
		held_set    = '0;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					rate = 8'd0;
					dly  = 8'd0;
				end
				1: begin
					rate = 8'hFF;
					dly  = 8'hFF;
				end
				2: begin
					rate = 8'd1;
					dly  = 8'd2;
				end
				3: begin
					rate = 8'd0;
					dly  = 8'd3;
				end
				4: begin
					rate = 8'd3;
					dly  = 8'd0;
				end
				5: begin
					rate = 8'($urandom_range(255));
					dly  = 8'($urandom_range(255));
				end
				6: begin
					rate = 8'($urandom_range(6));
					dly  = 8'($urandom_range(6));
				end
				default: begin
					rate = REPEAT_RATE_RST;
					dly  = REPEAT_DELAY_RST;
				end
			endcase
			write_reg(REG_BUTTON_MODE, 8'(p % 4) | 8'($urandom_range(63) << 2));
			write_reg(REG_REPEAT_RATE, rate);
			write_reg(REG_REPEAT_DELAY, dly);
			case ((p + 1) % 4)
				0: begin
					src_pct = 0;
					snk_pct = 0;
				end
				1: begin
					src_pct = 30;
					snk_pct = 0;
				end
				2: begin
					src_pct = 0;
					snk_pct = 30;
				end
				default: begin
					src_pct = 40;
					snk_pct = 40;
				end
			endcase
			for (int i = 0; i < 150; i++) begin
				if (i == 75)
					wait_drained();
				if (hold_left == 0) begin
					case ($urandom_range(7))
						0: held_set = '0;
						1: held_set = '1;
						2, 3: held_set = 16'($urandom());
						default: held_set = (16'($urandom()) & M_REMAPPED)
							| (16'(1) << $urandom_range(KEY_W - 1));
					endcase
					hold_left = ($urandom_range(11) == 0) ? $urandom_range(280, 20)
						: $urandom_range(12, 1);
				end
				hold_left--;
				if (stroke_left == 0) begin
					contact     = ~contact;
					stroke_left = $urandom_range(15, 1);
				end
				stroke_left--;
				lid = 1'b0;
				if (lid_left > 0) begin
					lid = 1'b1;
					lid_left--;
				end else if ($urandom_range(39) == 0) begin
					lid_left = $urandom_range(4, 1);
				end
				v = ($urandom_range(4) == 0) ? validity_t'($urandom_range(3)) : VAL_OK;
				send_word(make_frame(lid, held_set, contact ^ ($urandom_range(19) == 0),
					8'($urandom_range(255)), 8'($urandom_range(191)), v));
			end
		end
		src_pct = 0;
		snk_pct = 0;
	endtask

	// result side: random stalls on ready
	always @(negedge clk) begin
		if (snk_wait > 0) begin
			res.ready = 1'b0;
			snk_wait--;
		end else begin
			res.ready = 1'b1;
			snk_wait  = pick_gap(snk_pct);
		end
	end

	always @(posedge clk) begin
		out_word_t exp_w;
		if (res.valid && res.ready) begin
			if (pending_frames.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result word with nothing expected, got %h", $time,
						res.payload);
			end else begin
				exp_w = pending_frames.pop_front();
				check_field("held_keys", exp_w.held_keys, res.payload.held_keys);
				check_field("pressed_keys", exp_w.pressed_keys, res.payload.pressed_keys);
				check_field("repeat_keys", exp_w.repeat_keys, res.payload.repeat_keys);
				check_field("touch_x_out", KEY_W'(exp_w.touch_x_out),
					KEY_W'(res.payload.touch_x_out));
				check_field("touch_y_out", KEY_W'(exp_w.touch_y_out),
					KEY_W'(res.payload.touch_y_out));
				check_field("touch_pressed", KEY_W'(exp_w.touch_pressed),
					KEY_W'(res.payload.touch_pressed));
				check_field("touch_held", KEY_W'(exp_w.touch_held),
					KEY_W'(res.payload.touch_held));
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		smp.valid   = 1'b0;
		smp.payload = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_key_repeat();
		test_touch_latch();
		test_button_modes();
		test_random_phases();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("summary: %0d sample words, %0d results checked, %0d register writes",
			n_words, n_checked, n_cfg_writes);
		$display("summary: %0d autorepeat bursts, %0d lid-closed ticks, %0d mismatches",
			n_bursts, n_lid, errors);
		if (errors == 0 && pending_frames.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/kpat_pkg.sv
design/kpat_ifs.sv
design/keypad_autorepeat_touch_latch_unit.sv
design/kpat_checker.sv
tb/testbench.sv
